FILE: sv/tspwm_pkg.sv
`default_nettype none
package tspwm_pkg;

  localparam int ANGLE_W = 32;
  localparam int AMP_W = 7;
  localparam int DUTY_W = 16;
  localparam int GAIN_W = AMP_W + 3;
  localparam int LANES = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FRAC_W = 48;
  localparam int INV_W = 30;

  localparam logic [AMP_W-1:0] AMP_RESET = 7'd40;
  localparam logic [INV_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_c;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_a;
  } duty_t;

endpackage
`default_nettype wire

FILE: sv/three_phase_sine_pwm.sv
// an accepted angle passes front stages f1 and f2, the index queue and back stages b1 to b5 to the output
// throughput: one angle per cycle while the output is not stalled, set by the pipelined index and duty stages
// a 4-entry index queue between the angle front end and the duty back end
// reset: synchronous active-high rst empties all stages and the queue
// reset: amplitude returns to 40, no clearing pass
`default_nettype none
module three_phase_sine_pwm
  import tspwm_pkg::*;
#(
  parameter int TABLE_SIZE = 256,
  parameter int SINE_SCALE = 16384,
  parameter int PWM_PERIOD = 1000
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire  [ANGLE_W-1:0]   s_axis_tdata,  // angle
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [3*DUTY_W-1:0]  m_axis_tdata,  // duty_a, duty_b, duty_c
  input  wire                  cfg_wen,
  input  wire  [AMP_W-1:0]     cfg_wdata      // amplitude
);

  localparam int IDX_W = $clog2(TABLE_SIZE);

  logic [AMP_W-1:0] amplitude;
  logic fr_valid;
  logic fr_ready;
  logic [IDX_W-1:0] fr_idx;
  logic bk_valid;
  logic bk_ready;
  logic [IDX_W-1:0] bk_idx;
  duty_t duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= AMP_RESET;
    end else if (cfg_wen) begin
      amplitude <= cfg_wdata;
    end
  end

  tspwm_front #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_angle  (s_axis_tdata),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_idx   (fr_idx)
  );

  tspwm_fifo #(
    .WIDTH (IDX_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_idx),
    .out_valid (bk_valid),
    .out_ready (bk_ready),
    .out_data  (bk_idx)
  );

  tspwm_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .SINE_SCALE (SINE_SCALE),
    .PWM_PERIOD (PWM_PERIOD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .amplitude (amplitude),
    .in_valid  (bk_valid),
    .in_ready  (bk_ready),
    .in_idx    (bk_idx),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_duty  (duty)
  );

  assign m_axis_tdata = duty;

endmodule
`default_nettype wire

FILE: sv/tspwm_fifo.sv
`default_nettype none
module tspwm_fifo
  import tspwm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push;
  logic pop;

  assign in_ready = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/tspwm_front.sv
`default_nettype none
module tspwm_front
  import tspwm_pkg::*;
#(
  parameter int TABLE_SIZE = 256
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [ANGLE_W-1:0]                in_angle,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [$clog2(TABLE_SIZE)-1:0]     out_idx
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int TURN_W = ANGLE_W + INV_W;
  localparam int PROD_W = FRAC_W + IDX_W + 1;

  logic f1_valid;
  logic f1_neg;
  logic [ANGLE_W-1:0] f1_mag;
  logic f2_valid;
  logic f2_neg;
  logic [FRAC_W-1:0] f2_lo;

  logic adv1;
  logic adv2;
  logic [ANGLE_W-1:0] mag;
  logic [TURN_W-1:0] turns;
  logic [PROD_W-1:0] scaled;
  logic [IDX_W:0] rounded;
  logic [IDX_W-1:0] rem;

  assign adv2 = !f2_valid || out_ready;
  assign adv1 = !f1_valid || adv2;
  assign in_ready = adv1;

  // magnitude of the angle, the most negative value stays 2^31
  assign mag = in_angle[ANGLE_W-1] ? (~in_angle + 1'b1) : in_angle;
  assign turns = TURN_W'(f1_mag) * TURN_W'(INV_TWO_PI_Q32);

  // round to nearest index, remainder mod table size
  assign scaled = PROD_W'(f2_lo) * PROD_W'(TABLE_SIZE) + (PROD_W'(1) << (FRAC_W - 1));
  assign rounded = scaled[PROD_W-1:FRAC_W];
  assign rem = (rounded == (IDX_W + 1)'(TABLE_SIZE)) ? '0 : rounded[IDX_W-1:0];
  assign out_idx = (f2_neg && rem != '0) ? (IDX_W'(TABLE_SIZE) - rem) : rem;
  assign out_valid = f2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (adv1) begin
        f1_valid <= in_valid;
      end
      if (adv2) begin
        f2_valid <= f1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      f1_neg <= in_angle[ANGLE_W-1];
      f1_mag <= mag;
    end
    if (adv2) begin
      f2_neg <= f1_neg;
      f2_lo <= turns[FRAC_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: sv/tspwm_back.sv
`default_nettype none
module tspwm_back
  import tspwm_pkg::*;
#(
  parameter int TABLE_SIZE = 256,
  parameter int SINE_SCALE = 16384,
  parameter int PWM_PERIOD = 1000
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire  [AMP_W-1:0]              amplitude,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [$clog2(TABLE_SIZE)-1:0] in_idx,
  output logic                          out_valid,
  input  wire                           out_ready,
  output duty_t                         out_duty
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int RV_W = $clog2(SINE_SCALE + 1) + 1;
  localparam int NUM_W = RV_W + GAIN_W + 1;
  localparam int SH_K = NUM_W + $clog2(SINE_SCALE);
  localparam int RCP_W = NUM_W + 1;
  localparam int PRD_W = NUM_W + RCP_W;
  localparam int Q_W = PRD_W - SH_K;
  localparam int V_W = ((Q_W > DUTY_W) ? Q_W : DUTY_W) + 2;
  localparam longint unsigned RECIP =
    ((64'd1 << SH_K) + 64'(SINE_SCALE) - 64'd1) / 64'(SINE_SCALE);
  localparam int OFF_B = TABLE_SIZE / 3;
  localparam int OFF_C = (2 * TABLE_SIZE + 1) / 3;

  function automatic logic signed [RV_W-1:0] sine_entry(int i);
    logic [63:0] ph;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mg;
    logic neg;
    ph = (64'(i) << 32) / 64'(TABLE_SIZE);
    neg = 1'b0;
    if (ph >= (64'd1 << 31)) begin
      neg = 1'b1;
      ph = ph - (64'd1 << 31);
    end
    if (ph > Q30_ONE) begin
      ph = (64'd1 << 31) - ph;
    end
    x = (ph * TWO_PI_Q30) >> 32;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    for (int k = 19; k >= 3; k -= 2) begin
      t = Q30_ONE - ((x2 * t) >> 30) / 64'(k * (k - 1));
    end
    s = (x * t) >> 30;
    mg = (s * 64'(SINE_SCALE) + (64'd1 << 29)) >> 30;
    return neg ? -RV_W'(mg) : RV_W'(mg);
  endfunction

  logic signed [RV_W-1:0] sine_rom [TABLE_SIZE];

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_rom
    localparam logic signed [RV_W-1:0] ENTRY = sine_entry(i);
    assign sine_rom[i] = ENTRY;
  end

  logic b1_valid;
  logic b2_valid;
  logic b3_valid;
  logic b4_valid;
  logic b5_valid;
  logic [IDX_W-1:0] b1_idx [LANES];
  logic signed [RV_W-1:0] b2_rom [LANES];
  logic signed [NUM_W-1:0] b3_num [LANES];
  logic b4_neg [LANES];
  logic [PRD_W-1:0] b4_prd [LANES];
  duty_t duty;

  logic adv1;
  logic adv2;
  logic adv3;
  logic adv4;
  logic adv5;
  logic [IDX_W:0] sum_b;
  logic [IDX_W:0] sum_c;
  logic [IDX_W-1:0] idx_next [LANES];
  logic [GAIN_W-1:0] gain;
  logic signed [NUM_W-1:0] gain_ext;
  logic signed [NUM_W-1:0] num_next [LANES];
  logic [NUM_W-1:0] abs_num [LANES];
  logic [PRD_W-1:0] prd_next [LANES];
  logic signed [V_W-1:0] v [LANES];
  logic [DUTY_W-1:0] clamped [LANES];

  assign adv5 = !b5_valid || out_ready;
  assign adv4 = !b4_valid || adv5;
  assign adv3 = !b3_valid || adv4;
  assign adv2 = !b2_valid || adv3;
  assign adv1 = !b1_valid || adv2;
  assign in_ready = adv1;

  // phase offsets of one and two thirds of a turn
  assign sum_b = (IDX_W + 1)'(in_idx) + (IDX_W + 1)'(OFF_B);
  assign sum_c = (IDX_W + 1)'(in_idx) + (IDX_W + 1)'(OFF_C);
  assign idx_next[0] = in_idx;
  assign idx_next[1] = (sum_b >= (IDX_W + 1)'(TABLE_SIZE)) ?
                       IDX_W'(sum_b - (IDX_W + 1)'(TABLE_SIZE)) : IDX_W'(sum_b);
  assign idx_next[2] = (sum_c >= (IDX_W + 1)'(TABLE_SIZE)) ?
                       IDX_W'(sum_c - (IDX_W + 1)'(TABLE_SIZE)) : IDX_W'(sum_c);

  assign gain = GAIN_W'({amplitude, 2'b00}) + GAIN_W'(amplitude);
  assign gain_ext = signed'(NUM_W'(gain));

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num_next[l] = NUM_W'(b2_rom[l]) * gain_ext + NUM_W'(SINE_SCALE / 2);
      abs_num[l] = b3_num[l][NUM_W-1] ? NUM_W'(-b3_num[l]) : NUM_W'(b3_num[l]);
      prd_next[l] = PRD_W'(abs_num[l]) * PRD_W'(RCP_W'(RECIP));
      // quotient rounds toward zero, then centered on half period
      v[l] = b4_neg[l] ? -V_W'(b4_prd[l][PRD_W-1:SH_K]) : V_W'(b4_prd[l][PRD_W-1:SH_K]);
      v[l] = v[l] + V_W'(PWM_PERIOD / 2);
      if (v[l] < 0) begin
        clamped[l] = '0;
      end else if (v[l] > V_W'(PWM_PERIOD)) begin
        clamped[l] = DUTY_W'(PWM_PERIOD);
      end else begin
        clamped[l] = DUTY_W'(v[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      b4_valid <= 1'b0;
      b5_valid <= 1'b0;
    end else begin
      if (adv1) begin
        b1_valid <= in_valid;
      end
      if (adv2) begin
        b2_valid <= b1_valid;
      end
      if (adv3) begin
        b3_valid <= b2_valid;
      end
      if (adv4) begin
        b4_valid <= b3_valid;
      end
      if (adv5) begin
        b5_valid <= b4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (adv1) begin
        b1_idx[l] <= idx_next[l];
      end
      if (adv2) begin
        b2_rom[l] <= sine_rom[b1_idx[l]];
      end
      if (adv3) begin
        b3_num[l] <= num_next[l];
      end
      if (adv4) begin
        b4_neg[l] <= b3_num[l][NUM_W-1];
        b4_prd[l] <= prd_next[l];
      end
    end
    if (adv5) begin
      duty.duty_a <= clamped[0];
      duty.duty_b <= clamped[1];
      duty.duty_c <= clamped[2];
    end
  end

  assign out_valid = b5_valid;
  assign out_duty = duty;

endmodule
`default_nettype wire

FILE: tb/sv/three_phase_sine_pwm_test.sv
`default_nettype none
module three_phase_sine_pwm_test;
  import tspwm_pkg::*;

  localparam int N_TAB = 256;
  localparam int SCALE = 16384;
  localparam int PERIOD = 1000;
  localparam int LIMIT = 200000;
  localparam int TAIL = 20;
  localparam int N_PHASES = 7;
  localparam int PHASE_ITEMS = 236;
  localparam logic [63:0] INV_2PI_Q32 = 64'd683565276;
  localparam logic [63:0] TWOPI_Q30 = 64'd6746518852;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam real STEP_Q16 = 2.0 * 3.14159265358979 * 65536.0 / 256.0;
  localparam duty_t MID_DUTY = {3{16'd500}};

  typedef struct {
    logic [AMP_W-1:0] amp;
    logic [ANGLE_W-1:0] angle;
    bit typed;
    duty_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ANGLE_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [3*DUTY_W-1:0] m_axis_tdata;
  logic cfg_wen = 1'b0;
  logic [AMP_W-1:0] cfg_wdata = '0;

  bit row_typed = 1'b0;
  duty_t row_want = '0;
  bit quiet = 1'b0;
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  logic [AMP_W-1:0] amp_mirror = AMP_RESET;
  int sine_tab [N_TAB];
  duty_t exp_duty_q [$];
  stim_row_t rows [$];

  three_phase_sine_pwm #(
    .TABLE_SIZE(N_TAB),
    .SINE_SCALE(SCALE),
    .PWM_PERIOD(PERIOD)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int sine_value(int i);
    logic [63:0] ph, x, x2, t, s, mag;
    bit neg;
    ph = (64'(i) << 32) / 64'(N_TAB);
    neg = 1'b0;
    if (ph >= (64'd1 << 31)) begin
      neg = 1'b1;
      ph = ph - (64'd1 << 31);
    end
    if (ph > (64'd1 << 30)) ph = (64'd1 << 31) - ph;
    x = (ph * TWOPI_Q30) >> 32;
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    for (int k = 19; k >= 3; k -= 2)
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'(k * (k - 1));
    s = (x * t) >> 30;
    mag = (s * 64'(SCALE) + (64'd1 << 29)) >> 30;
    return neg ? -int'(mag) : int'(mag);
  endfunction

  function automatic int angle_to_index(logic [ANGLE_W-1:0] raw);
    logic [31:0] neg_raw;
    logic [63:0] mag, turns, hi, lo, idx_mag, r;
    neg_raw = ~raw + 32'd1;
    mag = raw[31] ? {32'd0, neg_raw} : {32'd0, raw};
    turns = mag * INV_2PI_Q32;
    hi = turns >> 48;
    lo = turns & ((64'd1 << 48) - 64'd1);
    idx_mag = hi * 64'(N_TAB) + ((lo * 64'(N_TAB) + (64'd1 << 47)) >> 48);
    r = idx_mag % 64'(N_TAB);
    return (raw[31] && r != 0) ? N_TAB - int'(r) : int'(r);
  endfunction

  function automatic logic [DUTY_W-1:0] phase_duty_of(int k, logic [AMP_W-1:0] amp);
    longint gain, num, v;
    gain = 5 * longint'(amp);
    num = longint'(sine_tab[k % N_TAB]) * gain + longint'(SCALE / 2);
    v = num / longint'(SCALE) + longint'(PERIOD / 2);
    if (v < 0) v = 0;
    if (v > PERIOD) v = PERIOD;
    return v[DUTY_W-1:0];
  endfunction

  function automatic duty_t predict_duties(logic [ANGLE_W-1:0] angle, logic [AMP_W-1:0] amp);
    duty_t d;
    int idx;
    idx = angle_to_index(angle);
    d.duty_a = phase_duty_of(idx, amp);
    d.duty_b = phase_duty_of((idx + N_TAB / 3) % N_TAB, amp);
    d.duty_c = phase_duty_of((idx + (2 * N_TAB + 1) / 3) % N_TAB, amp);
    return d;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at result %0d, %s: got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  task automatic check_field(string what, logic [DUTY_W-1:0] got, logic [DUTY_W-1:0] want);
    if (got !== want) report_mismatch(what, int'(got), int'(want));
  endtask

  // scoreboard: outputs checked before the same-edge input is queued
  always @(posedge clk) begin
    duty_t got;
    duty_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst) begin
      amp_mirror = AMP_RESET;
    end else begin
      if (cfg_wen) amp_mirror = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        got = duty_t'(m_axis_tdata);
        if (exp_duty_q.size() == 0) begin
          report_mismatch("unexpected transaction duty_a", int'(got.duty_a), -1);
        end else begin
          want = exp_duty_q.pop_front();
          check_field("duty_a", got.duty_a, want.duty_a);
          check_field("duty_b", got.duty_b, want.duty_b);
          check_field("duty_c", got.duty_c, want.duty_c);
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready)
        exp_duty_q.push_back(row_typed ? row_want : predict_duties(s_axis_tdata, amp_mirror));
    end
  end

  always @(negedge clk)
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 28);

  task automatic send_angle(logic [ANGLE_W-1:0] a, bit typed, duty_t want);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= a;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_all_duties();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (exp_duty_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_amp(logic [AMP_W-1:0] v);
    wait_all_duties();
    repeat (12) @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic add_row(logic [AMP_W-1:0] amp, logic [ANGLE_W-1:0] angle, bit typed,
                         duty_t want);
    stim_row_t r;
    r.amp = amp;
    r.angle = angle;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endtask

  function automatic logic [ANGLE_W-1:0] gen_angle();
    int k, off, a;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2, 3, 4, 5: begin
        a = $urandom_range(0, 1647100) - 823550;
        return a;
      end
      6, 7, 8: begin
        // near a half-step of the table index, where rounding decides
        k = $urandom_range(0, 1023);
        off = $urandom_range(0, 4) - 2;
        a = $rtoi((k + 0.5) * STEP_Q16) + off;
        return $urandom_range(0, 1) ? -a : a;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [AMP_W-1:0] cur_amp;
    int phase_amp [N_PHASES];
    for (int i = 0; i < N_TAB; i++) sine_tab[i] = sine_value(i);
    phase_amp = '{127, 0, 100, -1, -1, 40, -1};

    add_row(7'd40, 32'd0, 1'b0, '0);
    add_row(7'd40, 32'd1, 1'b0, '0);
    add_row(7'd40, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(7'd40, 32'h7FFF_FFFF, 1'b0, '0);
    add_row(7'd40, 32'h8000_0000, 1'b0, '0);
    add_row(7'd40, 32'd102944, 1'b0, '0);
    add_row(7'd40, -32'sd102944, 1'b0, '0);
    add_row(7'd40, 32'd205887, 1'b0, '0);
    add_row(7'd40, 32'd411775, 1'b0, '0);
    add_row(7'd40, -32'sd411775, 1'b0, '0);
    add_row(7'd0, 32'd0, 1'b1, MID_DUTY);
    add_row(7'd0, 32'h7FFF_FFFF, 1'b1, MID_DUTY);
    add_row(7'd0, 32'h8000_0000, 1'b1, MID_DUTY);
    add_row(7'd0, -32'sd102944, 1'b1, MID_DUTY);
    add_row(7'd127, 32'd102944, 1'b0, '0);
    add_row(7'd127, -32'sd102944, 1'b0, '0);
    add_row(7'd127, 32'd0, 1'b0, '0);
    add_row(7'd127, 32'd205887, 1'b0, '0);
    add_row(7'd100, 32'd102944, 1'b0, '0);
    add_row(7'd100, -32'sd102944, 1'b0, '0);
    add_row(7'd100, 32'h7FFF_FFFF, 1'b0, '0);
    add_row(7'd1, 32'd102944, 1'b0, '0);
    add_row(7'd1, -32'sd51472, 1'b0, '0);

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    cur_amp = AMP_RESET;
    foreach (rows[i]) begin
      if (rows[i].amp != cur_amp) begin
        write_amp(rows[i].amp);
        cur_amp = rows[i].amp;
      end
      send_angle(rows[i].angle, rows[i].typed, rows[i].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_amp(phase_amp[p] < 0 ? AMP_W'($urandom_range(0, 127)) : AMP_W'(phase_amp[p]));
      quiet = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 120) wait_all_duties();
        send_angle(gen_angle(), 1'b0, '0);
      end
    end
    quiet = 1'b0;

    wait_all_duties();
    repeat (TAIL) @(negedge clk);
    if (exp_duty_q.size() != 0)
      report_mismatch("results never arrived", 0, exp_duty_q.size());
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
sv/tspwm_pkg.sv
sv/tspwm_fifo.sv
sv/tspwm_front.sv
sv/tspwm_back.sv
sv/three_phase_sine_pwm.sv
tb/sv/three_phase_sine_pwm_test.sv
